// File: rtl/ccsc_pkg.sv
package ccsc_pkg;

  localparam int unsigned CfgCount = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_KEY_A = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_B = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_C = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_D = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_A = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_B = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_NONCE_C = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SETUP = 3'd7;

  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_SEEK    = 2'd1,
    MODE_CRYPT   = 2'd2,
    MODE_STREAM  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    NF_NONE = 2'd0,
    NF_64   = 2'd1,
    NF_96   = 2'd2,
    NF_192  = 2'd3
  } nonce_fmt_t;

  typedef logic [31:0] word_t;

  localparam word_t Sigma32 [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};
  localparam word_t Sigma16 [4] = '{32'h61707865, 32'h3120646e, 32'h79622d36, 32'h6b206574};

  // Quarter-round word indexes, column round first then diagonal round.
  typedef logic [3:0] widx_t;
  localparam widx_t QrA [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd3};
  localparam widx_t QrB [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
  localparam widx_t QrC [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
  localparam widx_t QrD [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

  function automatic word_t rotl(input word_t v, input int unsigned r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction

endpackage

// File: rtl/ccsc_stream_if.sv
interface ccsc_stream_if #(
  parameter int unsigned Width = 8
) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ccsc_in_if.sv
interface ccsc_in_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic [63:0] seek_offset;

  modport source (output valid, output mode, output data_byte, output seek_offset, input ready);
  modport sink (input valid, input mode, input data_byte, input seek_offset, output ready);
endinterface

// File: rtl/chacha_stream_cipher_core.sv
// ChaCha stream cipher core. Write key, nonce and setup registers on the cfg
// port while idle, then send a restart item (mode 0); it builds the state,
// runs HChaCha first for the 192-bit nonce format, and makes the first block.
// A seek item (mode 1) positions the stream at a byte offset. Byte items
// (mode 2 XOR data, mode 3 raw keystream) return one out_byte each. A block
// runs one quarter-round step a cycle on a single shared quarter-round unit,
// after the item is taken: state load, rounds, 16 feed-forward adds, counter
// step; restart with XChaCha first runs the HChaCha load, its rounds and the
// subkey load. A byte item leaves the core idle, except the one that reads the
// last byte of a block (position 63), which also makes the next block before
// the core is ready again. Results sit in an output register; while a result
// waits on a stalled sink, hold off the next item.
module chacha_stream_cipher_core #(
  parameter int unsigned ROUNDS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ccsc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ccsc_pkg::CfgDataW-1:0] cfg_data,
  ccsc_in_if.sink                      in_ch,
  ccsc_stream_if.source                out_ch
);

  localparam int unsigned DblRounds = ROUNDS / 2;
  localparam int unsigned StepCount = DblRounds * 8;
  localparam int unsigned StepW = $clog2(StepCount + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROUND  = 5'b00010,
    ST_ADD    = 5'b00100,
    ST_HLOAD  = 5'b01000,
    ST_CNT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] cfg_r [7];
  logic [2:0]  setup_r;

  ccsc_pkg::word_t block_key_r [8];
  ccsc_pkg::word_t cn_r [4];
  ccsc_pkg::word_t x_r [16];
  ccsc_pkg::word_t ks_r [16];
  logic            short_r;
  logic            hchacha_r;
  logic [5:0]      pos_r;
  logic [StepW-1:0] step_r;
  logic [3:0]      add_r;

  logic [7:0] out_byte_r;
  logic       out_valid_r;

  // Input words of the block from the current state.
  ccsc_pkg::word_t w_in [16];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_in[i] = short_r ? ccsc_pkg::Sigma16[i] : ccsc_pkg::Sigma32[i];
      w_in[12 + i] = cn_r[i];
    end
    for (int i = 0; i < 8; i++) w_in[4 + i] = block_key_r[i];
  end

  // Shared quarter-round unit.
  logic [2:0] qsel;
  ccsc_pkg::word_t qa, qb, qc, qd, a1, d1, c1, b1, a2, d2, c2, b2;
  assign qsel = step_r[2:0];
  always_comb begin
    qa = x_r[ccsc_pkg::QrA[qsel]];
    qb = x_r[ccsc_pkg::QrB[qsel]];
    qc = x_r[ccsc_pkg::QrC[qsel]];
    qd = x_r[ccsc_pkg::QrD[qsel]];
    a1 = qa + qb;  d1 = ccsc_pkg::rotl(qd ^ a1, 16);
    c1 = qc + d1;  b1 = ccsc_pkg::rotl(qb ^ c1, 12);
    a2 = a1 + b1;  d2 = ccsc_pkg::rotl(d1 ^ a2, 8);
    c2 = c1 + d2;  b2 = ccsc_pkg::rotl(b1 ^ c2, 7);
  end

  logic accept;
  logic byte_take;
  logic busy_out;
  assign busy_out = out_valid_r && !out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !busy_out;
  assign accept = in_ch.valid && in_ch.ready;
  assign byte_take = accept && (in_ch.mode == ccsc_pkg::MODE_CRYPT ||
                                in_ch.mode == ccsc_pkg::MODE_STREAM);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_byte_r;

  logic [1:0] fmt;
  ccsc_pkg::word_t kw [8];
  ccsc_pkg::word_t nw [6];
  always_comb begin
    fmt = setup_r[2:1];
    for (int i = 0; i < 8; i++) kw[i] = i[0] ? cfg_r[i >> 1][63:32] : cfg_r[i >> 1][31:0];
    for (int i = 0; i < 6; i++) nw[i] = i[0] ? cfg_r[4 + (i >> 1)][63:32]
                                            : cfg_r[4 + (i >> 1)][31:0];
  end

  logic [7:0] ks_byte;
  assign ks_byte = ks_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == ccsc_pkg::MODE_RESTART || in_ch.mode == ccsc_pkg::MODE_SEEK)
            state_nxt = ST_HLOAD;
          else if (pos_r == 6'd63) state_nxt = ST_HLOAD;
        end
      end
      // After HChaCha, stay in ST_HLOAD to load the block with the subkey.
      ST_HLOAD: state_nxt = (hchacha_r && step_r != '0) ? ST_HLOAD : ST_ROUND;
      ST_ROUND: if (step_r == StepW'(StepCount - 1)) state_nxt = hchacha_r ? ST_HLOAD : ST_ADD;
      ST_ADD:   if (add_r == 4'd15) state_nxt = ST_CNT;
      ST_CNT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 7; i++) cfg_r[i] <= '0;
      setup_r <= '0;
      for (int i = 0; i < 8; i++) block_key_r[i] <= '0;
      for (int i = 0; i < 4; i++) cn_r[i] <= '0;
      short_r <= 1'b0;
      hchacha_r <= 1'b0;
      pos_r <= '0;
      step_r <= '0;
      add_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == ccsc_pkg::CFG_SETUP) setup_r <= cfg_data[2:0];
        else cfg_r[cfg_index] <= cfg_data;
      end
      if (byte_take) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_ch.mode)
              ccsc_pkg::MODE_RESTART: begin
                // Latch key and nonce layout; flag HChaCha for XChaCha.
                short_r <= setup_r[0];
                for (int i = 0; i < 8; i++) block_key_r[i] <= setup_r[0] ? kw[i & 3] : kw[i];
                hchacha_r <= (fmt == ccsc_pkg::NF_192);
                case (fmt)
                  ccsc_pkg::NF_64: begin
                    cn_r[0] <= '0; cn_r[1] <= '0;
                    cn_r[2] <= nw[0]; cn_r[3] <= nw[1];
                  end
                  ccsc_pkg::NF_96: begin
                    cn_r[0] <= '0;
                    cn_r[1] <= nw[0]; cn_r[2] <= nw[1]; cn_r[3] <= nw[2];
                  end
                  ccsc_pkg::NF_192: begin
                    for (int i = 0; i < 4; i++) cn_r[i] <= nw[i];
                  end
                  default: begin
                    cn_r[0] <= '0; cn_r[1] <= '0; cn_r[2] <= '0; cn_r[3] <= '0;
                  end
                endcase
                pos_r <= '0;
              end
              ccsc_pkg::MODE_SEEK: begin
                cn_r[0] <= in_ch.seek_offset[37:6];
                cn_r[1] <= cn_r[1] + {6'd0, in_ch.seek_offset[63:38]};
                pos_r <= in_ch.seek_offset[5:0];
              end
              default: begin
                out_byte_r <= (in_ch.mode == ccsc_pkg::MODE_CRYPT)
                              ? (ks_byte ^ in_ch.data_byte) : ks_byte;
                pos_r <= pos_r + 6'd1;
              end
            endcase
          end
        end
        ST_HLOAD: begin
          // After HChaCha, take the subkey and lay out the XChaCha nonce; else load the block state.
          if (hchacha_r && step_r != '0) begin
            for (int i = 0; i < 4; i++) begin
              block_key_r[i] <= x_r[i];
              block_key_r[4 + i] <= x_r[12 + i];
            end
            cn_r[0] <= '0; cn_r[1] <= '0;
            cn_r[2] <= nw[4]; cn_r[3] <= nw[5];
            hchacha_r <= 1'b0;
            step_r <= '0;
          end else begin
            for (int i = 0; i < 16; i++) x_r[i] <= w_in[i];
            step_r <= '0;
          end
        end
        ST_ROUND: begin
          x_r[ccsc_pkg::QrA[qsel]] <= a2;
          x_r[ccsc_pkg::QrB[qsel]] <= b2;
          x_r[ccsc_pkg::QrC[qsel]] <= c2;
          x_r[ccsc_pkg::QrD[qsel]] <= d2;
          if (step_r == StepW'(StepCount - 1)) begin
            add_r <= '0;
            // Mark HChaCha done with a nonzero step; else park at zero.
            step_r <= hchacha_r ? StepW'(1) : '0;
          end else begin
            step_r <= step_r + StepW'(1);
          end
        end
        ST_ADD: begin
          // Feed-forward, one word a cycle through the shared adder.
          ks_r[add_r] <= x_r[add_r] + w_in[add_r];
          add_r <= add_r + 4'd1;
        end
        ST_CNT: begin
          cn_r[0] <= cn_r[0] + 32'd1;
          if (cn_r[0] == 32'hffff_ffff) cn_r[1] <= cn_r[1] + 32'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ccsc_checker.sv
module ccsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data
);
  // Byte items yield a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == ccsc_pkg::MODE_CRYPT || in_mode == ccsc_pkg::MODE_STREAM)
    |=> out_valid) else $error("byte item gave no result");
  // Control items yield no result but start a block, which drops ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == ccsc_pkg::MODE_RESTART || in_mode == ccsc_pkg::MODE_SEEK)
    |=> !in_ready) else $error("control item did not start block");
  // Held result stays.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  // Ready drops while a result stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("accepting over stalled result");
endmodule

bind chacha_stream_cipher_core ccsc_checker u_ccsc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: tb/ccsc_keystream_checker.sv
module ccsc_keystream_checker #(
  parameter int unsigned ROUNDS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ccsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ccsc_pkg::CfgDataW-1:0] cfg_data,
  ccsc_in_if                            in_ch,
  ccsc_stream_if                        out_ch,
  output int                            fail_count,
  output int                            bytes_pending,
  output int                            bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ccsc_pkg::*;

  typedef word_t blk_t [16];

  logic [CfgDataW-1:0] regs_q [CfgCount];
  word_t               key_q [8];
  word_t               ctr_q [4];
  blk_t                ks_q;
  logic [5:0]          pos_q;
  logic                short_key_q;
  logic [7:0]          byte_q [$];

  function automatic word_t rol(word_t v, int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  // ROUNDS/2 double rounds, no feed-forward
  function automatic blk_t scramble(blk_t x);
    blk_t y = x;
    int a, b, c, d;
    for (int r = 0; r < ROUNDS / 2; r++) begin
      for (int q = 0; q < 8; q++) begin
        a = QrA[q]; b = QrB[q]; c = QrC[q]; d = QrD[q];
        y[a] += y[b]; y[d] = rol(y[d] ^ y[a], 16);
        y[c] += y[d]; y[b] = rol(y[b] ^ y[c], 12);
        y[a] += y[b]; y[d] = rol(y[d] ^ y[a], 8);
        y[c] += y[d]; y[b] = rol(y[b] ^ y[c], 7);
      end
    end
    return y;
  endfunction

  function automatic blk_t block_input();
    blk_t w;
    for (int i = 0; i < 4; i++) begin
      w[i] = short_key_q ? Sigma16[i] : Sigma32[i];
      w[12 + i] = ctr_q[i];
    end
    for (int i = 0; i < 8; i++) w[4 + i] = key_q[i];
    return w;
  endfunction

  task automatic next_block();
    blk_t w, x;
    w = block_input();
    x = scramble(w);
    for (int i = 0; i < 16; i++) ks_q[i] = x[i] + w[i];
    ctr_q[0] += 1;
    if (ctr_q[0] == 0) ctr_q[1] += 1;
  endtask

  task automatic restart_state();
    word_t      k [8];
    word_t      n [6];
    blk_t       x;
    nonce_fmt_t fmt;
    for (int i = 0; i < 8; i++) k[i] = regs_q[i >> 1][32 * (i & 1) +: 32];
    for (int i = 0; i < 6; i++) n[i] = regs_q[CFG_NONCE_A + (i >> 1)][32 * (i & 1) +: 32];
    short_key_q = regs_q[CFG_SETUP][0];
    fmt = nonce_fmt_t'(regs_q[CFG_SETUP][2:1]);
    for (int i = 0; i < 8; i++) key_q[i] = short_key_q ? k[i & 3] : k[i];
    ctr_q = '{default: '0};
    case (fmt)
      NF_64: begin
        ctr_q[2] = n[0]; ctr_q[3] = n[1];
      end
      NF_96: begin
        ctr_q[1] = n[0]; ctr_q[2] = n[1]; ctr_q[3] = n[2];
      end
      NF_192: begin
        for (int i = 0; i < 4; i++) ctr_q[i] = n[i];
        x = scramble(block_input());
        for (int i = 0; i < 4; i++) begin
          key_q[i] = x[i];
          key_q[4 + i] = x[12 + i];
        end
        ctr_q = '{32'd0, 32'd0, n[4], n[5]};
      end
      default: ;
    endcase
    next_block();
    pos_q = '0;
  endtask

  always @(posedge clk) begin
    logic [7:0]  ks_byte;
    logic [7:0]  want;
    logic [63:0] blk_num;
    if (!rst_n) begin
      regs_q = '{default: '0};
      key_q = '{default: '0};
      ctr_q = '{default: '0};
      ks_q = '{default: '0};
      pos_q = '0;
      short_key_q = 1'b0;
      byte_q.delete();
      fail_count = 0;
      bytes_seen = 0;
    end else begin
      // a result at this edge can only come from an earlier item
      if (out_ch.valid && out_ch.ready) begin
        bytes_seen++;
        if (byte_q.size() == 0) begin
          $display("%0t unexpected out_byte %02h", $time, out_ch.data);
          fail_count++;
        end else begin
          want = byte_q.pop_front();
          if (out_ch.data !== want) begin
            $display("%0t out_byte mismatch: expected %02h, actual %02h",
                     $time, want, out_ch.data);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        regs_q[cfg_index] = (cfg_index == CFG_SETUP) ? (cfg_data & 64'd7) : cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        case (mode_t'(in_ch.mode))
          MODE_RESTART: restart_state();
          MODE_SEEK: begin
            blk_num = in_ch.seek_offset >> 6;
            ctr_q[0] = blk_num[31:0];
            ctr_q[1] += blk_num[63:32];
            next_block();
            pos_q = in_ch.seek_offset[5:0];
          end
          default: begin
            ks_byte = 8'(ks_q[pos_q[5:2]] >> (8 * pos_q[1:0]));
            if (mode_t'(in_ch.mode) == MODE_CRYPT) ks_byte ^= in_ch.data_byte;
            byte_q.push_back(ks_byte);
            pos_q = pos_q + 6'd1;
            if (pos_q == 0) next_block();
          end
        endcase
      end
    end
    bytes_pending = byte_q.size();
  end

endmodule

// File: tb/chacha_stream_cipher_core_tb.sv
module chacha_stream_cipher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccsc_pkg::*;

  // Quiet cycles the watchdog tolerates: an XChaCha restart, a full block,
  // the idle pause before register writes and the longest stalls fit well inside.
  localparam int unsigned IdleLimit = 3000;
  // Pause after the last result before touching registers: covers a restart
  // with HChaCha plus a block at ROUNDS=20.
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned NumPhases = 11;
  localparam int unsigned ItemsPerPhase = 38;

  typedef logic [CfgDataW-1:0] cfg_set_t [CfgCount];

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  ccsc_in_if in_ch ();
  ccsc_stream_if #(.Width(8)) out_ch ();

  int  fail_count;
  int  bytes_pending;
  int  bytes_seen;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;   // no gaps and no stalls while set

  chacha_stream_cipher_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ccsc_keystream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending),
    .bytes_seen    (bytes_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Drive every input to a known value from time zero.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_RESTART;
    in_ch.data_byte = '0;
    in_ch.seek_offset = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, IdleLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: before each item, hold ready low for a randomly drawn stall
  // (none while calm), then keep it high until that item is taken.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Present one item after a random gap; valid stays high into the next
  // item when the gap is zero, so it is never dropped and raised in one step.
  task automatic send_item(mode_t m, logic [7:0] d, logic [63:0] off);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.data_byte <= d;
    in_ch.seek_offset <= off;
    items_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, drain every expected byte, then let a pending block finish.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (bytes_pending == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_regs(cfg_set_t v);
    for (int i = 0; i < CfgCount; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CfgIdxW-1:0];
      cfg_data <= v[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    logic [63:0] off;
    pick = $urandom_range(0, 99);
    off = {$urandom(), $urandom()};
    if (pick < 4) begin
      send_item(MODE_RESTART, 8'($urandom()), off);
    end else if (pick < 12) begin
      // half of the seeks land near the stream start so block wraps follow soon
      if (pick < 8) off = 64'($urandom_range(0, 300));
      send_item(MODE_SEEK, 8'($urandom()), off);
    end else if (pick < 56) begin
      send_item(MODE_CRYPT, 8'($urandom()), off);
    end else begin
      send_item(MODE_STREAM, 8'($urandom()), off);
    end
  endtask

  initial begin
    cfg_set_t regs;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero key, 256-bit key, no nonce.
    regs = '{default: '0};
    write_regs(regs);
    send_item(MODE_RESTART, 8'h00, 64'd0);
    send_item(MODE_STREAM, 8'h00, 64'd0);
    send_item(MODE_STREAM, 8'hff, 64'd0);
    send_item(MODE_CRYPT, 8'h00, 64'd0);
    send_item(MODE_CRYPT, 8'hff, 64'd0);
    send_item(MODE_SEEK, 8'h00, 64'd0);
    send_item(MODE_STREAM, 8'h00, 64'd0);
    // land on the last byte so the next read wraps into a fresh block
    send_item(MODE_SEEK, 8'h00, 64'd63);
    send_item(MODE_STREAM, 8'h00, 64'd0);
    send_item(MODE_CRYPT, 8'h5a, 64'd0);
    // largest offset: high half of the block number folds into word 13
    send_item(MODE_SEEK, 8'h00, 64'hffff_ffff_ffff_ffff);
    send_item(MODE_STREAM, 8'h00, 64'd0);
    send_item(MODE_STREAM, 8'h00, 64'd0);
    // low counter word at all ones: the wrap carries into word 13
    send_item(MODE_SEEK, 8'h00, {26'd0, 32'hffff_ffff, 6'd62});
    send_item(MODE_STREAM, 8'h00, 64'd0);
    send_item(MODE_STREAM, 8'h00, 64'd0);
    send_item(MODE_STREAM, 8'h00, 64'd0);
    send_item(MODE_RESTART, 8'h00, 64'd0);
    send_item(MODE_CRYPT, 8'ha5, 64'd0);
    send_item(MODE_CRYPT, 8'h3c, 64'd0);

    // Random phases: new registers each time, every setup value visited,
    // all-ones registers with 128-bit key and XChaCha first.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      calm = (p % 4 == 3);
      if (p == 0) begin
        regs = '{default: '1};
      end else begin
        for (int i = 0; i < CfgCount; i++) regs[i] = {$urandom(), $urandom()};
        regs[CFG_SETUP] = 64'(p % 8);
        if (p == 1) regs[CFG_SETUP] = 64'hffff_ffff_ffff_fff6;  // upper bits ignored
      end
      write_regs(regs);
      send_item(MODE_RESTART, 8'($urandom()), {$urandom(), $urandom()});
      for (int i = 0; i < ItemsPerPhase; i++) random_item();
    end

    drain();
    $display("Sent %0d items over %0d register settings; %0d keystream bytes checked.",
             items_sent, NumPhases + 1, bytes_seen);
    $display("Covered all nonce formats, both key sizes, seeks and block wraps.");
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ccsc_pkg.sv
rtl/ccsc_stream_if.sv
rtl/ccsc_in_if.sv
rtl/chacha_stream_cipher_core.sv
rtl/ccsc_checker.sv
tb/ccsc_keystream_checker.sv
tb/chacha_stream_cipher_core_tb.sv
